### rtl/core/mcumm_pkg.sv
package mcumm_pkg;

    localparam int IRAM_DEPTH = 128;
    localparam int SFR_DEPTH = 128;
    localparam int INT_DEPTH = IRAM_DEPTH + SFR_DEPTH;
    localparam int XRAM_DEPTH_DEF = 65536;
    localparam int CODE_DEPTH_DEF = 65536;

    localparam logic OP_WRITE = 1'b1;

    localparam logic [2:0] SPACE_IRAM = 3'd0;
    localparam logic [2:0] SPACE_XRAM = 3'd1;
    localparam logic [2:0] SPACE_CODE = 3'd2;
    localparam logic [2:0] SPACE_SFR = 3'd3;
    localparam logic [2:0] SPACE_BIT = 3'd4;

    localparam logic [7:0] SFR_SP = 8'h81;
    localparam logic [7:0] SFR_SCON = 8'h98;
    localparam logic [7:0] SFR_SBUF = 8'h99;
    localparam logic [7:0] SP_RESET = 8'h07;
    localparam logic [7:0] TI_MASK = 8'h02;
    localparam logic [3:0] BIT_IRAM_BASE = 4'h2;

    typedef enum logic [2:0] {
        K_NONE,
        K_IRAM,
        K_XRAM,
        K_CODE,
        K_BIT,
        K_SBUF_RD,
        K_SBUF_WR
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        wr;
        logic [7:0]  iaddr;
        logic [2:0]  bit_sel;
        logic [7:0]  data;
        logic [7:0]  rx;
        logic [15:0] addr;
        logic        iram_re;
        logic        iram_we;
        logic        xram_re;
        logic        xram_we;
        logic        code_re;
        logic        code_we;
    } op_t;

endpackage

### rtl/core/mcumm_if.sv
interface mcumm_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  space;
    logic [15:0] address;
    logic [7:0]  write_byte;
    logic [7:0]  serial_rx_byte;

    modport source (output valid, output opcode, output space, output address,
                    output write_byte, output serial_rx_byte, input ready);
    modport sink (input valid, input opcode, input space, input address,
                  input write_byte, input serial_rx_byte, output ready);
endinterface

interface mcumm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;

    modport source (output valid, output read_byte, output tx_valid, output tx_byte,
                    output rx_taken, input ready);
    modport sink (input valid, input read_byte, input tx_valid, input tx_byte,
                  input rx_taken, output ready);
endinterface

### rtl/core/mcumm_ram.sv
module mcumm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/core/mcumm_decode.sv
module mcumm_decode
    import mcumm_pkg::*;
(
    input  logic        opcode,
    input  logic [2:0]  space,
    input  logic [15:0] address,
    input  logic [7:0]  write_byte,
    input  logic [7:0]  serial_rx_byte,
    output op_t         op
);

    logic [7:0] a8;
    kind_t      sfr_kind;

    assign a8 = address[7:0];

    always_comb
    begin
        if (a8 == SFR_SBUF)
        begin
            sfr_kind = (opcode == OP_WRITE) ? K_SBUF_WR : K_SBUF_RD;
        end
        else if (!a8[7])
        begin
            sfr_kind = K_NONE;
        end
        else
        begin
            sfr_kind = K_IRAM;
        end
    end

    always_comb
    begin
        op = '0;
        op.wr = (opcode == OP_WRITE);
        op.bit_sel = a8[2:0];
        op.data = write_byte;
        op.rx = serial_rx_byte;
        op.addr = address;
        op.iaddr = a8;
        op.kind = K_NONE;
        case (space)
            SPACE_IRAM: op.kind = a8[7] ? sfr_kind : K_IRAM;
            SPACE_XRAM: op.kind = K_XRAM;
            SPACE_CODE: op.kind = K_CODE;
            SPACE_SFR:  op.kind = sfr_kind;
            SPACE_BIT:
            begin
                op.kind = K_BIT;
                if (a8[7])
                begin
                    op.iaddr = {1'b1, a8[6:3], 3'b000};
                end
                else
                begin
                    op.iaddr = {BIT_IRAM_BASE, a8[6:3]};
                end
            end
            default: op.kind = K_NONE;
        endcase
        if (op.kind == K_SBUF_WR)
        begin
            op.iaddr = SFR_SCON;
        end
        op.iram_re = (op.kind == K_IRAM && !op.wr) || op.kind == K_BIT
                     || op.kind == K_SBUF_WR;
        op.iram_we = (op.kind == K_IRAM && op.wr);
        op.xram_re = (op.kind == K_XRAM && !op.wr);
        op.xram_we = (op.kind == K_XRAM && op.wr);
        op.code_re = (op.kind == K_CODE && !op.wr);
        op.code_we = (op.kind == K_CODE && op.wr);
    end

endmodule

### rtl/core/mcu8051_memory_map_top.sv
// Memory map of an 8051: internal RAM with SFRs, external RAM, code memory and
// bit space, reached through one request channel and one response channel.
// Every accepted request gives exactly one response with the read data and the
// serial port strobes.
// A request is accepted in the idle state and its response is loaded into the
// output register in the done state, once the output register is free; no new
// request is accepted until that response has been loaded.
// The done state comes from the registered read of the RAMs: a bit write or a
// serial buffer write reads the byte and writes it back in the done state.
// After reset the block sweeps external RAM, internal RAM and the SFRs to
// their reset values, one address a cycle; no request is accepted during the
// sweep. Code memory is not cleared.
// A new request is accepted while a response still waits; if the receiver
// stalls, the block holds the next result back until the output is free.
// XRAM_DEPTH and CODE_DEPTH must be powers of two.
module mcu8051_memory_map_top
    import mcumm_pkg::*;
#(
    parameter int XRAM_DEPTH = XRAM_DEPTH_DEF,
    parameter int CODE_DEPTH = CODE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    mcumm_req_if.sink     req,
    mcumm_rsp_if.source   rsp
);

    localparam int XA_W = $clog2(XRAM_DEPTH);
    localparam int CA_W = $clog2(CODE_DEPTH);
    localparam int IA_W = $clog2(INT_DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DONE
    } state_t;

    state_t          state_reg;
    logic [XA_W-1:0] clr_reg;
    op_t             op_reg;
    logic            rsp_valid_reg;
    logic [7:0]      read_byte_reg;
    logic            tx_valid_reg;
    logic [7:0]      tx_byte_reg;
    logic            rx_taken_reg;

    op_t             dec_op;
    logic            accept;
    logic            out_free;

    logic            iram_we;
    logic            iram_re;
    logic [IA_W-1:0] iram_addr;
    logic [7:0]      iram_wdata;
    logic [7:0]      iram_rdata;
    logic            xram_we;
    logic            xram_re;
    logic [XA_W-1:0] xram_addr;
    logic [7:0]      xram_wdata;
    logic [7:0]      xram_rdata;
    logic            code_we;
    logic            code_re;
    logic [7:0]      code_rdata;

    logic [7:0]      bit_mask;
    logic [7:0]      wb_byte;
    logic            wb_en;
    logic [7:0]      rd_byte;
    logic            rd_txv;
    logic [7:0]      rd_txb;
    logic            rd_rxt;

    mcumm_decode u_decode (
        .opcode         (req.opcode),
        .space          (req.space),
        .address        (req.address),
        .write_byte     (req.write_byte),
        .serial_rx_byte (req.serial_rx_byte),
        .op             (dec_op)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign bit_mask = 8'd1 << op_reg.bit_sel;

    always_comb
    begin
        wb_byte = iram_rdata | TI_MASK;
        wb_en = 1'b0;
        if (op_reg.kind == K_BIT && op_reg.wr)
        begin
            wb_en = 1'b1;
            wb_byte = op_reg.data[0] ? (iram_rdata | bit_mask) : (iram_rdata & ~bit_mask);
        end
        else if (op_reg.kind == K_SBUF_WR)
        begin
            wb_en = 1'b1;
        end
    end

    always_comb
    begin
        iram_we = 1'b0;
        iram_re = 1'b0;
        iram_addr = dec_op.iaddr;
        iram_wdata = dec_op.data;
        xram_we = 1'b0;
        xram_re = 1'b0;
        xram_addr = dec_op.addr[XA_W-1:0];
        xram_wdata = dec_op.data;
        code_we = 1'b0;
        code_re = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                iram_we = (32'(clr_reg) < INT_DEPTH);
                iram_addr = clr_reg[IA_W-1:0];
                iram_wdata = (clr_reg[IA_W-1:0] == SFR_SP) ? SP_RESET : 8'd0;
                xram_we = 1'b1;
                xram_addr = clr_reg;
                xram_wdata = 8'd0;
            end
            ST_IDLE:
            begin
                iram_we = accept && dec_op.iram_we;
                iram_re = accept && dec_op.iram_re;
                xram_we = accept && dec_op.xram_we;
                xram_re = accept && dec_op.xram_re;
                code_we = accept && dec_op.code_we;
                code_re = accept && dec_op.code_re;
            end
            ST_DONE:
            begin
                iram_addr = op_reg.iaddr;
                iram_wdata = wb_byte;
                iram_we = out_free && wb_en;
            end
            default:
            begin
                iram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_byte = 8'd0;
        rd_txv = 1'b0;
        rd_txb = 8'd0;
        rd_rxt = 1'b0;
        case (op_reg.kind)
            K_IRAM:    rd_byte = op_reg.wr ? 8'd0 : iram_rdata;
            K_XRAM:    rd_byte = op_reg.wr ? 8'd0 : xram_rdata;
            K_CODE:    rd_byte = op_reg.wr ? 8'd0 : code_rdata;
            K_BIT:     rd_byte = op_reg.wr ? 8'd0 : {7'd0, iram_rdata[op_reg.bit_sel]};
            K_SBUF_RD:
            begin
                rd_byte = op_reg.rx;
                rd_rxt = 1'b1;
            end
            K_SBUF_WR:
            begin
                rd_txv = 1'b1;
                rd_txb = op_reg.data;
            end
            default:   rd_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            op_reg <= '0;
            rsp_valid_reg <= 1'b0;
            read_byte_reg <= 8'd0;
            tx_valid_reg <= 1'b0;
            tx_byte_reg <= 8'd0;
            rx_taken_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && state_reg != ST_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == XA_W'(XRAM_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= dec_op;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg <= 1'b1;
                        read_byte_reg <= rd_byte;
                        tx_valid_reg <= rd_txv;
                        tx_byte_reg <= rd_txb;
                        rx_taken_reg <= rd_rxt;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.read_byte = read_byte_reg;
    assign rsp.tx_valid = tx_valid_reg;
    assign rsp.tx_byte = tx_byte_reg;
    assign rsp.rx_taken = rx_taken_reg;

    mcumm_ram #(
        .WIDTH (8),
        .DEPTH (INT_DEPTH)
    ) u_iram (
        .clk   (clk),
        .we    (iram_we),
        .re    (iram_re),
        .addr  (iram_addr),
        .wdata (iram_wdata),
        .rdata (iram_rdata)
    );

    mcumm_ram #(
        .WIDTH (8),
        .DEPTH (XRAM_DEPTH)
    ) u_xram (
        .clk   (clk),
        .we    (xram_we),
        .re    (xram_re),
        .addr  (xram_addr),
        .wdata (xram_wdata),
        .rdata (xram_rdata)
    );

    mcumm_ram #(
        .WIDTH (8),
        .DEPTH (CODE_DEPTH)
    ) u_code (
        .clk   (clk),
        .we    (code_we),
        .re    (code_re),
        .addr  (dec_op.addr[CA_W-1:0]),
        .wdata (dec_op.data),
        .rdata (code_rdata)
    );

endmodule
